FILE: hw/rtl/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

	// Action codes of an input item. Code 3 is ignored.
	localparam logic [1:0] ACT_LOAD_NODE = 2'd0;
	localparam logic [1:0] ACT_LOAD_FEAT = 2'd1;
	localparam logic [1:0] ACT_CLASSIFY  = 2'd2;

	// Register index of tree_count and its value after reset.
	localparam logic       REG_TREE_COUNT   = 1'b0;
	localparam logic [4:0] TREE_COUNT_RESET = 5'd16;

	// Vote counts above this value are reported saturated.
	localparam logic [4:0] VOTE_COUNT_MAX = 5'd31;

	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         tree_index;
		logic [7:0]         node_index;
		logic               node_is_leaf;
		logic [4:0]         split_feature;
		logic signed [15:0] split_threshold;
		logic [3:0]         leaf_class;
		logic signed [15:0] feature_value;
	} in_item_t;

	typedef struct packed {
		logic [3:0] class_label;
		logic [4:0] vote_count;
	} out_item_t;

	typedef struct packed {
		logic load_node;
		logic load_feat;
		logic start;
		logic vote;
		logic step;
		logic scan;
		logic emit;
	} rfc_cmd_t;

	typedef struct packed {
		logic trees_zero;
		logic leaf_stop;
		logic last_tree;
		logic scan_last;
		logic out_free;
	} rfc_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rfc_ram.sv
`default_nettype none

module rfc_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rfc_ctrl.sv
`default_nettype none

module rfc_ctrl import rfc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	input  wire logic [1:0] action,
	input  wire rfc_sts_t   sts,
	output rfc_cmd_t        cmd,
	output logic            idle
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_NODE = 6'b000010,
		ST_EVAL = 6'b000100,
		ST_CMP  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign idle   = (state_q == ST_IDLE);
	assign accept = item_valid && idle;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (action)
						ACT_LOAD_NODE: cmd.load_node = 1'b1;
						ACT_LOAD_FEAT: cmd.load_feat = 1'b1;
						ACT_CLASSIFY: begin
							cmd.start = 1'b1;
							state_d   = sts.trees_zero ? ST_SCAN : ST_NODE;
						end
						default: ;
					endcase
				end
			end
			// The node address is presented here; its data is read in EVAL.
			ST_NODE: state_d = ST_EVAL;
			ST_EVAL: begin
				if (sts.leaf_stop) begin
					cmd.vote = 1'b1;
					state_d  = sts.last_tree ? ST_SCAN : ST_NODE;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.step = 1'b1;
				state_d  = ST_NODE;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTH
	a_classify_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_CLASSIFY) |=> (state_q == ST_NODE || state_q == ST_SCAN))
		else $error("classify transfer did not start a walk or scan");

	a_node_then_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NODE) |=> (state_q == ST_EVAL))
		else $error("node read not followed by evaluation");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !sts.out_free) |=> (state_q == ST_DONE))
		else $error("result dropped while output register was full");

	a_emit_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (state_q == ST_DONE && sts.out_free))
		else $error("result issued outside of the done state");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/rfc_dp.sv
`default_nettype none

module rfc_dp import rfc_pkg::*; #(
	parameter int MAX_TREES  = 16,
	parameter int TREE_DEPTH = 8,
	parameter int FEATURES   = 32,
	parameter int CLASSES    = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire rfc_cmd_t   cmd,
	output rfc_sts_t        sts,
	input  wire in_item_t   item,
	input  wire logic [4:0] tree_count,
	output out_item_t       result,
	output logic            result_valid,
	input  wire logic       result_stall
);

	localparam int TW    = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
	localparam int TCW   = $clog2(MAX_TREES + 1);
	localparam int NODES = (1 << TREE_DEPTH) - 1;
	localparam int NAW   = TW + TREE_DEPTH;
	localparam int NW    = VALUE_BITS + 10;
	localparam int FAW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
	localparam int LVW   = (TREE_DEPTH > 1) ? $clog2(TREE_DEPTH) : 1;
	localparam int NCNT  = (CLASSES < 16) ? CLASSES : 16;
	localparam int NIW   = $clog2(NCNT);

	logic [TCW-1:0]        tree_q;
	logic [TCW-1:0]        trees_eff;
	logic [TREE_DEPTH-1:0] idx_q;
	logic [LVW-1:0]        level_q;
	logic [NIW-1:0]        scan_q;
	logic [TCW-1:0]        votes_q [NCNT];
	logic [TCW-1:0]        best_cnt_q;
	logic [3:0]            best_cls_q;
	out_item_t             result_q;
	logic                  result_valid_q;

	logic                         node_wr;
	logic [NAW-1:0]               node_wr_addr;
	logic [NW-1:0]                node_wr_data;
	logic [NAW-1:0]               node_rd_addr;
	logic [NW-1:0]                node_rdata;
	logic                         feat_wr;
	logic [FAW-1:0]               feat_wr_addr;
	logic [VALUE_BITS-1:0]        feat_wr_data;
	logic [FAW-1:0]               feat_rd_addr;
	logic [VALUE_BITS-1:0]        feat_rdata;

	logic                         nd_leaf;
	logic [4:0]                   nd_feat;
	logic [3:0]                   nd_cls;
	logic signed [VALUE_BITS-1:0] nd_thr;
	logic signed [VALUE_BITS-1:0] query;
	logic                         feat_ok;
	logic                         cls_ok;
	logic                         go_right;
	logic [NIW-1:0]               vote_idx;

	// Node entry layout: {leaf, feature, class, threshold}.
	assign node_wr = cmd.load_node && (32'(item.tree_index) < 32'(MAX_TREES))
		&& (32'(item.node_index) < 32'(NODES));
	assign node_wr_addr = {TW'(item.tree_index), TREE_DEPTH'(item.node_index)};
	assign node_wr_data = {item.node_is_leaf, item.split_feature, item.leaf_class,
		VALUE_BITS'(item.split_threshold)};
	assign node_rd_addr = {TW'(tree_q), idx_q};

	rfc_ram #(
		.WIDTH(NW),
		.DEPTH(1 << NAW)
	) u_node_ram (
		.clk    (clk),
		.wr_en  (node_wr),
		.wr_addr(node_wr_addr),
		.wr_data(node_wr_data),
		.rd_addr(node_rd_addr),
		.rd_data(node_rdata)
	);

	assign nd_leaf = node_rdata[NW-1];
	assign nd_feat = node_rdata[NW-2 -: 5];
	assign nd_cls  = node_rdata[NW-7 -: 4];
	assign nd_thr  = node_rdata[VALUE_BITS-1:0];

	assign feat_wr      = cmd.load_feat && (32'(item.split_feature) < 32'(FEATURES));
	assign feat_wr_addr = FAW'(item.split_feature);
	assign feat_wr_data = VALUE_BITS'(item.feature_value);
	// The node data stays put through EVAL and CMP, so the feature read
	// issued in EVAL is ready in CMP.
	assign feat_rd_addr = FAW'(nd_feat);

	rfc_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(FEATURES)
	) u_feat_ram (
		.clk    (clk),
		.wr_en  (feat_wr),
		.wr_addr(feat_wr_addr),
		.wr_data(feat_wr_data),
		.rd_addr(feat_rd_addr),
		.rd_data(feat_rdata)
	);

	// A node naming a feature beyond the vector compares against zero.
	assign feat_ok  = 32'(nd_feat) < 32'(FEATURES);
	assign query    = feat_ok ? feat_rdata : '0;
	assign go_right = query > nd_thr;

	assign cls_ok   = 32'(nd_cls) < 32'(CLASSES);
	assign vote_idx = NIW'(nd_cls);

	assign trees_eff = (32'(tree_count) > 32'(MAX_TREES)) ? TCW'(MAX_TREES)
		: TCW'(tree_count);

	assign sts.trees_zero = (trees_eff == '0);
	assign sts.leaf_stop  = nd_leaf || (level_q == LVW'(TREE_DEPTH - 1));
	assign sts.last_tree  = ((tree_q + TCW'(1)) == trees_eff);
	assign sts.scan_last  = (scan_q == NIW'(NCNT - 1));
	assign sts.out_free   = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_q         <= '0;
			idx_q          <= '0;
			level_q        <= '0;
			scan_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				tree_q  <= '0;
				idx_q   <= '0;
				level_q <= '0;
				scan_q  <= '0;
			end else if (cmd.vote) begin
				tree_q  <= tree_q + TCW'(1);
				idx_q   <= '0;
				level_q <= '0;
			end else if (cmd.step) begin
				idx_q   <= (idx_q << 1) + (go_right ? TREE_DEPTH'(2) : TREE_DEPTH'(1));
				level_q <= level_q + LVW'(1);
			end else if (cmd.scan) begin
				scan_q <= scan_q + NIW'(1);
			end

			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The scan rotates the counters so that class scan_q always sits at
	// position zero; a strict compare keeps the lowest class on a tie.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < NCNT; i++) begin
				votes_q[i] <= '0;
			end
			best_cnt_q <= '0;
			best_cls_q <= '0;
		end else if (cmd.vote) begin
			if (cls_ok) begin
				votes_q[vote_idx] <= votes_q[vote_idx] + TCW'(1);
			end
		end else if (cmd.scan) begin
			for (int i = 0; i < NCNT - 1; i++) begin
				votes_q[i] <= votes_q[i + 1];
			end
			votes_q[NCNT-1] <= votes_q[0];
			if (votes_q[0] > best_cnt_q) begin
				best_cnt_q <= votes_q[0];
				best_cls_q <= 4'(scan_q);
			end
		end

		if (cmd.emit) begin
			result_q.class_label <= best_cls_q;
			result_q.vote_count  <= (32'(best_cnt_q) > 32'(VOTE_COUNT_MAX))
				? VOTE_COUNT_MAX : 5'(best_cnt_q);
		end
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/random_forest_classify.sv
// Random forest classifier with majority vote.
// Item channel (item_valid, item_stall, item): a transfer happens when
// item_valid is high and item_stall is low. Node loads and feature loads
// are written in the cycle of their transfer and give no result; the block
// takes the next item in the following cycle. A classify item walks every
// tree in use, then scans the class counters.
// Classify steps: a start step, then per tree one node RAM read for each
// node visited and one feature RAM read for each internal node visited,
// then a scan of the min(CLASSES,16) class counters, then the load of the
// output register.
// item_stall is high for the whole classify walk.
// Result channel (result_valid, result_stall, result): one result per
// classify, held in an output register. While the receiver stalls, loads
// are still taken; a following classify finishes its walk and then waits
// until the pending result is transferred.
// Reset clears the controller and the output valid and sets tree_count to
// 16; the node table and query vector hold nothing until loaded.
// tree_count is written over the APB port at byte address 0.
`default_nettype none

module random_forest_classify import rfc_pkg::*; #(
	parameter int MAX_TREES  = 16,
	parameter int TREE_DEPTH = 8,
	parameter int FEATURES   = 32,
	parameter int CLASSES    = 16,
	parameter int VALUE_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire in_item_t    item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output out_item_t        result
);

	logic [4:0] tree_count_q;
	logic       cfg_wr;
	rfc_cmd_t   cmd;
	rfc_sts_t   sts;
	logic       idle;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tree_count_q <= TREE_COUNT_RESET;
		end else if (cfg_wr && paddr[2] == REG_TREE_COUNT) begin
			tree_count_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == REG_TREE_COUNT) ? 32'(tree_count_q) : '0;

	assign item_stall = !idle;

	rfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.action    (item.action),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle)
	);

	rfc_dp #(
		.MAX_TREES (MAX_TREES),
		.TREE_DEPTH(TREE_DEPTH),
		.FEATURES  (FEATURES),
		.CLASSES   (CLASSES),
		.VALUE_BITS(VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item        (item),
		.tree_count  (tree_count_q),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

`default_nettype wire
